// ----- rtl/dzhp_pkg.sv -----
// ----------------------------------------------------------------------------
// dzhp_pkg
// shared types, constants and the crc-32 byte step for the header parser
// ----------------------------------------------------------------------------
package dzhp_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned TdataW    = 168;

  localparam logic [7:0]  Magic0   = 8'h1f;
  localparam logic [7:0]  Magic1   = 8'h8b;
  localparam logic [7:0]  MethodDf = 8'd8;
  localparam logic [32:0] HlenInit = 33'd10;
  localparam logic [32:0] HlenMax  = 33'h1_ffff_ffff;
  localparam logic [31:0] CrcPoly  = 32'hedb8_8320;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_GZ   = 3'd1,
    ST_BAD_METH = 3'd2,
    ST_NO_EXTRA = 3'd3,
    ST_BAD_CHNK = 3'd4,
    ST_RANGE    = 3'd5,
    ST_CRC      = 3'd6,
    ST_TRUNC    = 3'd7
  } status_e;

  typedef enum logic [12:0] {
    PH_FIXED   = 13'b0_0000_0000_0001,
    PH_XLEN    = 13'b0_0000_0000_0010,
    PH_SUBHDR  = 13'b0_0000_0000_0100,
    PH_CHLEN   = 13'b0_0000_0000_1000,
    PH_CHCNT   = 13'b0_0000_0001_0000,
    PH_TABLE   = 13'b0_0000_0010_0000,
    PH_XSKIP   = 13'b0_0000_0100_0000,
    PH_NAME    = 13'b0_0000_1000_0000,
    PH_COMMENT = 13'b0_0001_0000_0000,
    PH_HCRC    = 13'b0_0010_0000_0000,
    PH_DONE    = 13'b0_0100_0000_0000,
    PH_NOTGZ   = 13'b0_1000_0000_0000,
    PH_BADM    = 13'b1_0000_0000_0000
  } phase_e;

  // results of one byte: an optional chunk entry, then an optional summary
  typedef struct packed {
    logic        ent_v;
    logic [15:0] idx;
    logic [15:0] size;
    logic [31:0] offset;
    logic        sum_v;
    status_e     status;
    logic [31:0] hlen;
    logic [15:0] chlen;
    logic [15:0] chcnt;
    logic [31:0] pend;
  } rec_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

// ----- rtl/dzhp_front.sv -----
// ----------------------------------------------------------------------------
// dzhp_front
// byte-serial header parser: classifies each byte and builds its result record
// ----------------------------------------------------------------------------
module dzhp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic                q_space_i,
  output logic                q_push_o,
  output dzhp_pkg::rec_t      q_rec_o
);

  dzhp_pkg::phase_e phase_q, phase_d;
  logic [16:0] fbc_q, fbc_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] chlen_q, chlen_d;
  logic [15:0] chcnt_q, chcnt_d;
  logic [32:0] psum_q, psum_d;
  logic [32:0] hlen_q, hlen_d;
  logic [31:0] crc_q, crc_d;
  logic        sdone_q, sdone_d;
  logic [31:0] fsize_q;

  logic        acc;
  logic        fin, crc_bad;
  logic [15:0] w;
  logic [16:0] nf;
  logic [32:0] xlen;
  logic [32:0] used;
  logic [34:0] pe8;
  dzhp_pkg::phase_e ph, nxt;
  dzhp_pkg::rec_t rec;

  function automatic logic [32:0] sat_add(logic [32:0] a, logic [16:0] v);
    logic [33:0] s;
    s = {1'b0, a} + {17'd0, v};
    return s[33] ? dzhp_pkg::HlenMax : s[32:0];
  endfunction

  function automatic dzhp_pkg::phase_e go_next(dzhp_pkg::phase_e from, logic [7:0] f);
    dzhp_pkg::phase_e r;
    r = dzhp_pkg::PH_DONE;
    priority if (from == dzhp_pkg::PH_XSKIP) begin
      if (f[3])      r = dzhp_pkg::PH_NAME;
      else if (f[4]) r = dzhp_pkg::PH_COMMENT;
      else if (f[1]) r = dzhp_pkg::PH_HCRC;
    end else if (from == dzhp_pkg::PH_NAME) begin
      if (f[4])      r = dzhp_pkg::PH_COMMENT;
      else if (f[1]) r = dzhp_pkg::PH_HCRC;
    end else begin
      if (f[1])      r = dzhp_pkg::PH_HCRC;
    end
    return r;
  endfunction

  assign in_ready_o = q_space_i;
  assign acc        = in_valid_i & q_space_i;
  assign w          = {in_byte_i, held_q};

  always_comb begin
    phase_d = phase_q;
    fbc_d   = fbc_q;
    flags_d = flags_q;
    held_d  = held_q;
    chlen_d = chlen_q;
    chcnt_d = chcnt_q;
    psum_d  = psum_q;
    hlen_d  = hlen_q;
    sdone_d = sdone_q;
    crc_d   = (phase_q != dzhp_pkg::PH_HCRC && phase_q != dzhp_pkg::PH_DONE) ?
              dzhp_pkg::crc_byte(crc_q, in_byte_i) : crc_q;
    rec     = '0;
    fin     = 1'b0;
    crc_bad = 1'b0;
    ph      = phase_q;
    nxt     = dzhp_pkg::PH_DONE;
    nf      = fbc_q + 17'd1;
    xlen    = hlen_q - 33'd12;
    used    = 33'd10 + {16'd0, chcnt_q, 1'b0};
    pe8     = '0;

    unique case (phase_q)
      dzhp_pkg::PH_FIXED, dzhp_pkg::PH_NOTGZ, dzhp_pkg::PH_BADM: begin
        if (fbc_q == 17'd0) held_d = in_byte_i;
        if (fbc_q == 17'd1 && (held_q != dzhp_pkg::Magic0 || in_byte_i != dzhp_pkg::Magic1))
          ph = dzhp_pkg::PH_NOTGZ;
        if (fbc_q == 17'd2 && ph == dzhp_pkg::PH_FIXED && in_byte_i != dzhp_pkg::MethodDf)
          ph = dzhp_pkg::PH_BADM;
        if (fbc_q == 17'd3) flags_d = in_byte_i;
        fbc_d   = nf;
        phase_d = ph;
        if (fbc_q >= 17'd9) begin
          priority if (ph == dzhp_pkg::PH_NOTGZ) begin
            rec.sum_v  = 1'b1;
            rec.status = dzhp_pkg::ST_NOT_GZ;
          end else if (ph == dzhp_pkg::PH_BADM) begin
            rec.sum_v  = 1'b1;
            rec.status = dzhp_pkg::ST_BAD_METH;
          end else if (!flags_d[2]) begin
            rec.sum_v  = 1'b1;
            rec.status = dzhp_pkg::ST_NO_EXTRA;
          end else begin
            phase_d = dzhp_pkg::PH_XLEN;
            fbc_d   = '0;
          end
        end
      end
      dzhp_pkg::PH_XLEN: begin
        if (fbc_q == 17'd0) begin
          held_d = in_byte_i;
          fbc_d  = 17'd1;
        end else begin
          hlen_d  = sat_add(hlen_q, {1'b0, w} + 17'd2);
          phase_d = dzhp_pkg::PH_SUBHDR;
          fbc_d   = '0;
        end
      end
      dzhp_pkg::PH_SUBHDR: begin
        fbc_d = nf;
        if (nf >= 17'd6) begin
          phase_d = dzhp_pkg::PH_CHLEN;
          fbc_d   = '0;
        end
      end
      dzhp_pkg::PH_CHLEN: begin
        if (fbc_q == 17'd0) begin
          held_d = in_byte_i;
          fbc_d  = 17'd1;
        end else begin
          chlen_d = w;
          phase_d = dzhp_pkg::PH_CHCNT;
          fbc_d   = '0;
        end
      end
      dzhp_pkg::PH_CHCNT: begin
        if (fbc_q == 17'd0) begin
          held_d = in_byte_i;
          fbc_d  = 17'd1;
        end else begin
          chcnt_d = w;
          if (chlen_q == 16'd0 || w == 16'd0) begin
            rec.sum_v  = 1'b1;
            rec.status = dzhp_pkg::ST_BAD_CHNK;
          end else begin
            phase_d = dzhp_pkg::PH_TABLE;
            fbc_d   = '0;
            psum_d  = '0;
          end
        end
      end
      dzhp_pkg::PH_TABLE: begin
        if (!fbc_q[0]) begin
          held_d = in_byte_i;
        end else begin
          rec.ent_v  = 1'b1;
          rec.idx    = fbc_q[16:1];
          rec.size   = w;
          rec.offset = psum_q[31:0];
          psum_d     = psum_q + {17'd0, w};
        end
        fbc_d = nf;
        if (!nf[0] && nf[16:1] >= chcnt_q) begin
          if (xlen > used) begin
            phase_d = dzhp_pkg::PH_XSKIP;
            fbc_d   = xlen[16:0] - used[16:0];
          end else begin
            fbc_d = '0;
            nxt   = go_next(dzhp_pkg::PH_XSKIP, flags_q);
            if (nxt == dzhp_pkg::PH_DONE) fin = 1'b1;
            else phase_d = nxt;
          end
        end
      end
      dzhp_pkg::PH_XSKIP: begin
        fbc_d = (fbc_q != 17'd0) ? fbc_q - 17'd1 : '0;
        if (fbc_d == 17'd0) begin
          nxt = go_next(dzhp_pkg::PH_XSKIP, flags_q);
          if (nxt == dzhp_pkg::PH_DONE) fin = 1'b1;
          else phase_d = nxt;
        end
      end
      dzhp_pkg::PH_NAME, dzhp_pkg::PH_COMMENT: begin
        hlen_d = sat_add(hlen_q, 17'd1);
        if (in_byte_i == 8'd0) begin
          fbc_d = '0;
          nxt   = go_next(phase_q, flags_q);
          if (nxt == dzhp_pkg::PH_DONE) fin = 1'b1;
          else phase_d = nxt;
        end
      end
      dzhp_pkg::PH_HCRC: begin
        if (fbc_q == 17'd0) begin
          held_d = in_byte_i;
          fbc_d  = 17'd1;
        end else begin
          hlen_d  = sat_add(hlen_q, 17'd2);
          fin     = 1'b1;
          crc_bad = (w != crc_q[15:0]);
        end
      end
      default: begin
      end
    endcase

    if (fin) begin
      pe8 = {2'b0, hlen_d} + {2'b0, psum_d} + 35'd8;
      rec.sum_v = 1'b1;
      priority if (crc_bad) rec.status = dzhp_pkg::ST_CRC;
      else if (hlen_d[32] || pe8 > {3'd0, fsize_q}) rec.status = dzhp_pkg::ST_RANGE;
      else rec.status = dzhp_pkg::ST_OK;
    end

    if (rec.sum_v) begin
      phase_d = dzhp_pkg::PH_DONE;
      sdone_d = 1'b1;
    end

    if (in_last_i && !sdone_d) begin
      rec.sum_v  = 1'b1;
      rec.status = dzhp_pkg::ST_TRUNC;
    end

    if (rec.sum_v && rec.status == dzhp_pkg::ST_OK) begin
      rec.hlen  = hlen_d[31:0];
      rec.chlen = chlen_d;
      rec.chcnt = chcnt_d;
      rec.pend  = hlen_d[31:0] + psum_d[31:0];
    end

    if (in_last_i) begin
      phase_d = dzhp_pkg::PH_FIXED;
      fbc_d   = '0;
      flags_d = '0;
      held_d  = '0;
      chlen_d = '0;
      chcnt_d = '0;
      psum_d  = '0;
      hlen_d  = dzhp_pkg::HlenInit;
      crc_d   = '0;
      sdone_d = 1'b0;
    end
  end

  assign q_push_o = acc & (rec.ent_v | rec.sum_v);
  assign q_rec_o  = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dzhp_pkg::PH_FIXED;
      fbc_q   <= '0;
      flags_q <= '0;
      held_q  <= '0;
      chlen_q <= '0;
      chcnt_q <= '0;
      psum_q  <= '0;
      hlen_q  <= dzhp_pkg::HlenInit;
      crc_q   <= '0;
      sdone_q <= 1'b0;
      fsize_q <= '0;
    end else begin
      if (acc) begin
        phase_q <= phase_d;
        fbc_q   <= fbc_d;
        flags_q <= flags_d;
        held_q  <= held_d;
        chlen_q <= chlen_d;
        chcnt_q <= chcnt_d;
        psum_q  <= psum_d;
        hlen_q  <= hlen_d;
        crc_q   <= crc_d;
        sdone_q <= sdone_d;
      end
      if (cfg_we_i) fsize_q <= cfg_wdata_i;
    end
  end

endmodule

// ----- rtl/dzhp_fifo.sv -----
// ----------------------------------------------------------------------------
// dzhp_fifo
// short record queue between the parser and the output stage
// ----------------------------------------------------------------------------
module dzhp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dzhp_pkg::rec_t push_rec_i,
  output logic           space_o,
  input  logic           pop_i,
  output logic           avail_o,
  output dzhp_pkg::rec_t head_o
);

  dzhp_pkg::rec_t mem_q [dzhp_pkg::FifoDepth];
  logic [dzhp_pkg::PtrW-1:0] wr_q, rd_q;
  logic [dzhp_pkg::PtrW:0]   cnt_q;

  assign space_o = (cnt_q != (dzhp_pkg::PtrW+1)'(dzhp_pkg::FifoDepth));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (dzhp_pkg::PtrW+1)'(push_i) - (dzhp_pkg::PtrW+1)'(pop_i);
    end
  end

endmodule

// ----- rtl/dzhp_back.sv -----
// ----------------------------------------------------------------------------
// dzhp_back
// output stage: holds one record and sends its entry and summary in order
// ----------------------------------------------------------------------------
module dzhp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        avail_i,
  input  dzhp_pkg::rec_t              head_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [dzhp_pkg::TdataW-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser
);

  dzhp_pkg::rec_t cur_q, cur_d;
  logic           vld_q, vld_d;
  logic           xfer, done;

  assign xfer = vld_q & m_axis_tready;
  assign done = xfer & ~(cur_q.ent_v & cur_q.sum_v);
  assign pop_o = avail_i & (~vld_q | done);

  always_comb begin
    cur_d = cur_q;
    vld_d = vld_q;
    if (xfer && !done) cur_d.ent_v = 1'b0;
    if (done) vld_d = 1'b0;
    if (pop_o) begin
      cur_d = head_i;
      vld_d = 1'b1;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = ~cur_q.ent_v;
  assign m_axis_tlast  = ~(cur_q.ent_v & cur_q.sum_v);
  assign m_axis_tdata  = cur_q.ent_v ?
    {5'd0, 32'd0, 16'd0, 16'd0, 32'd0, cur_q.offset, cur_q.size, cur_q.idx,
     dzhp_pkg::ST_OK} :
    {5'd0, cur_q.pend, cur_q.chcnt, cur_q.chlen, cur_q.hlen, 32'd0, 16'd0, 16'd0,
     cur_q.status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// ----- rtl/dictzip_header_parser.sv -----
// ----------------------------------------------------------------------------
// dictzip_header_parser
// one file byte per transfer; results go via the queue to the output register
// throughput 1 byte per cycle while the queue has room; two results go out in turn
// a 4-record queue lets the parser run ahead of a stalled output
// reset (rst_ni low, async) clears parser state, file size and the queue
// ----------------------------------------------------------------------------
module dictzip_header_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [31:0]                 cfg_wdata_i,   // file_size
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // byte_value
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status, chunk_index, packed_size, relative_offset, header_length,
  // chunk_length, chunk_count, payload_end, zero pad
  output logic [dzhp_pkg::TdataW-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser   // kind
);

  logic           space, push, pop, avail;
  dzhp_pkg::rec_t push_rec, head;

  dzhp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_space_i   (space),
    .q_push_o    (push),
    .q_rec_o     (push_rec)
  );

  dzhp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .space_o    (space),
    .pop_i      (pop),
    .avail_o    (avail),
    .head_o     (head)
  );

  dzhp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (avail),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- dv/dictzip_header_parser_checker.sv -----
// ----------------------------------------------------------------------------
// dictzip_header_parser_checker
// watches the byte and result channels of the header parser, predicts the
// chunk entries and summaries of every accepted byte and compares each result
// transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
module dictzip_header_parser_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [31:0]                 cfg_wdata_i,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [7:0]                  s_tdata_i,
  input  logic                        s_tlast_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [dzhp_pkg::TdataW-1:0] m_tdata_i,
  input  logic                        m_tlast_i,
  input  logic                        m_tuser_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  typedef struct {
    logic              kind;
    dzhp_pkg::status_e status;
    logic [15:0]       cidx;
    logic [15:0]       psize;
    logic [31:0]       roff;
    logic [31:0]       hlen;
    logic [15:0]       chlen;
    logic [15:0]       chcnt;
    logic [31:0]       pend;
    logic              eor;
  } header_result_t;

  header_result_t expected_q[$];
  header_result_t byte_q[$];
  int             fail_total;

  // parser mirror
  logic [31:0]      fsize;
  dzhp_pkg::phase_e phase;
  logic [16:0]      fcnt;
  logic [7:0]       flags;
  logic [7:0]       held;
  logic [15:0]      chlen;
  logic [15:0]      chcnt;
  logic [32:0]      psum;
  logic [32:0]      hlen;
  logic [31:0]      crc;
  logic             done;

  function automatic logic [31:0] crc_step(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = ~c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hedb8_8320) : (c >> 1);
    return ~c;
  endfunction

  task automatic clear_parser();
    phase = dzhp_pkg::PH_FIXED;
    fcnt  = '0;
    flags = '0;
    held  = '0;
    chlen = '0;
    chcnt = '0;
    psum  = '0;
    hlen  = dzhp_pkg::HlenInit;
    crc   = '0;
    done  = 1'b0;
  endtask

  task automatic hlen_add(logic [32:0] v);
    logic [33:0] s;
    s = {1'b0, hlen} + {1'b0, v};
    hlen = (s > {1'b0, dzhp_pkg::HlenMax}) ? dzhp_pkg::HlenMax : s[32:0];
  endtask

  task automatic stage_result(header_result_t r);
    byte_q.insert(byte_q.size(), r);
  endtask

  task automatic push_entry(logic [15:0] i, logic [15:0] sz);
    header_result_t r;
    r = '{kind: 1'b0, status: dzhp_pkg::ST_OK, cidx: i, psize: sz, roff: psum[31:0],
          hlen: '0, chlen: '0, chcnt: '0, pend: '0, eor: 1'b0};
    stage_result(r);
  endtask

  task automatic push_summary(dzhp_pkg::status_e st);
    header_result_t r;
    logic [33:0]    pe;
    pe = {1'b0, hlen} + {1'b0, psum};
    r = '{kind: 1'b1, status: st, cidx: '0, psize: '0, roff: '0,
          hlen: '0, chlen: '0, chcnt: '0, pend: '0, eor: 1'b0};
    if (st == dzhp_pkg::ST_OK) begin
      r.hlen  = hlen[31:0];
      r.chlen = chlen;
      r.chcnt = chcnt;
      r.pend  = pe[31:0];
    end
    stage_result(r);
    phase = dzhp_pkg::PH_DONE;
    done  = 1'b1;
  endtask

  task automatic close_header(logic crc_bad);
    logic [33:0]       pe;
    dzhp_pkg::status_e st;
    pe = {1'b0, hlen} + {1'b0, psum};
    st = dzhp_pkg::ST_OK;
    if (crc_bad) st = dzhp_pkg::ST_CRC;
    else if (hlen > 33'hffff_ffff || pe > {2'b0, fsize} || ({2'b0, fsize} - pe) < 34'd8)
      st = dzhp_pkg::ST_RANGE;
    push_summary(st);
  endtask

  // next optional section after the given one; 1 when none remains
  function automatic logic next_section(dzhp_pkg::phase_e from);
    fcnt = '0;
    if (from < dzhp_pkg::PH_NAME && flags[3]) begin
      phase = dzhp_pkg::PH_NAME;
      return 1'b0;
    end
    if (from < dzhp_pkg::PH_COMMENT && flags[4]) begin
      phase = dzhp_pkg::PH_COMMENT;
      return 1'b0;
    end
    if (from < dzhp_pkg::PH_HCRC && flags[1]) begin
      phase = dzhp_pkg::PH_HCRC;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_byte(logic [7:0] b, logic lst);
    logic [16:0]    idx;
    logic [15:0]    w;
    logic [33:0]    xlen;
    logic [33:0]    used;
    header_result_t r;
    idx = fcnt;
    w   = {b, held};
    byte_q.delete();
    if (phase != dzhp_pkg::PH_HCRC && phase != dzhp_pkg::PH_DONE) crc = crc_step(crc, b);
    case (phase)
      dzhp_pkg::PH_FIXED, dzhp_pkg::PH_NOTGZ, dzhp_pkg::PH_BADM: begin
        if (idx == 0) held = b;
        if (idx == 1 && (held != dzhp_pkg::Magic0 || b != dzhp_pkg::Magic1))
          phase = dzhp_pkg::PH_NOTGZ;
        if (idx == 2 && phase == dzhp_pkg::PH_FIXED && b != dzhp_pkg::MethodDf)
          phase = dzhp_pkg::PH_BADM;
        if (idx == 3) flags = b;
        fcnt = idx + 17'd1;
        if (idx >= 9) begin
          if (phase == dzhp_pkg::PH_NOTGZ) push_summary(dzhp_pkg::ST_NOT_GZ);
          else if (phase == dzhp_pkg::PH_BADM) push_summary(dzhp_pkg::ST_BAD_METH);
          else if (!flags[2]) push_summary(dzhp_pkg::ST_NO_EXTRA);
          else begin
            phase = dzhp_pkg::PH_XLEN;
            fcnt  = '0;
          end
        end
      end
      dzhp_pkg::PH_XLEN: begin
        if (idx == 0) begin
          held = b;
          fcnt = 17'd1;
        end else begin
          hlen_add({17'd0, w} + 33'd2);
          phase = dzhp_pkg::PH_SUBHDR;
          fcnt  = '0;
        end
      end
      dzhp_pkg::PH_SUBHDR: begin
        fcnt = idx + 17'd1;
        if (fcnt >= 6) begin
          phase = dzhp_pkg::PH_CHLEN;
          fcnt  = '0;
        end
      end
      dzhp_pkg::PH_CHLEN: begin
        if (idx == 0) begin
          held = b;
          fcnt = 17'd1;
        end else begin
          chlen = w;
          phase = dzhp_pkg::PH_CHCNT;
          fcnt  = '0;
        end
      end
      dzhp_pkg::PH_CHCNT: begin
        if (idx == 0) begin
          held = b;
          fcnt = 17'd1;
        end else begin
          chcnt = w;
          if (chlen == 0 || chcnt == 0) push_summary(dzhp_pkg::ST_BAD_CHNK);
          else begin
            phase = dzhp_pkg::PH_TABLE;
            fcnt  = '0;
            psum  = '0;
          end
        end
      end
      dzhp_pkg::PH_TABLE: begin
        if (!idx[0]) held = b;
        else begin
          push_entry(idx[16:1], w);
          psum = psum + {17'd0, w};
        end
        fcnt = idx + 17'd1;
        if (!fcnt[0] && fcnt[16:1] >= chcnt) begin
          xlen = {1'b0, hlen} - 34'd12;
          used = 34'd10 + {17'd0, chcnt, 1'b0};
          if (xlen > used) begin
            phase = dzhp_pkg::PH_XSKIP;
            fcnt  = 17'(xlen - used);
          end else if (next_section(dzhp_pkg::PH_XSKIP)) close_header(1'b0);
        end
      end
      dzhp_pkg::PH_XSKIP: begin
        if (fcnt > 0) fcnt = fcnt - 17'd1;
        if (fcnt == 0 && next_section(dzhp_pkg::PH_XSKIP)) close_header(1'b0);
      end
      dzhp_pkg::PH_NAME, dzhp_pkg::PH_COMMENT: begin
        hlen_add(33'd1);
        if (b == 0 && next_section(phase)) close_header(1'b0);
      end
      dzhp_pkg::PH_HCRC: begin
        if (idx == 0) begin
          held = b;
          fcnt = 17'd1;
        end else begin
          hlen_add(33'd2);
          close_header(w != crc[15:0]);
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (!done) push_summary(dzhp_pkg::ST_TRUNC);
      clear_parser();
    end
    while (byte_q.size() > 0) begin
      r = byte_q.pop_front();
      if (byte_q.size() == 0) r.eor = 1'b1;
      expected_q.insert(expected_q.size(), r);
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fail_total++;
    end
  endfunction

  task automatic check_result();
    header_result_t e;
    if (expected_q.size() == 0) begin
      $error("result transfer with no prediction: tdata %0h", m_tdata_i);
      fail_total++;
      return;
    end
    e = expected_q.pop_front();
    compare_field("kind", 32'(e.kind), 32'(m_tuser_i));
    compare_field("status", 32'(e.status), 32'(m_tdata_i[2:0]));
    compare_field("chunk_index", 32'(e.cidx), 32'(m_tdata_i[18:3]));
    compare_field("packed_size", 32'(e.psize), 32'(m_tdata_i[34:19]));
    compare_field("relative_offset", e.roff, m_tdata_i[66:35]);
    compare_field("header_length", e.hlen, m_tdata_i[98:67]);
    compare_field("chunk_length", 32'(e.chlen), 32'(m_tdata_i[114:99]));
    compare_field("chunk_count", 32'(e.chcnt), 32'(m_tdata_i[130:115]));
    compare_field("payload_end", e.pend, m_tdata_i[162:131]);
    compare_field("end_of_run", 32'(e.eor), 32'(m_tlast_i));
  endtask

  initial begin
    fail_total = 0;
    fsize      = '0;
    clear_parser();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsize = '0;
      clear_parser();
      expected_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) check_result();
      if (s_tvalid_i && s_tready_i) predict_byte(s_tdata_i, s_tlast_i);
      if (cfg_we_i) fsize = cfg_wdata_i;
    end
    fail_count_o <= fail_total;
    pending_o    <= expected_q.size();
  end

endmodule

// ----- dv/dictzip_header_parser_tb.sv -----
// ----------------------------------------------------------------------------
// dictzip_header_parser_tb
// feeds files byte by byte into the header parser: directed headers for
// every status, then random well-formed headers mixed with broken and noisy
// files, with bursty input and a stalling output; the checker judges results
// ----------------------------------------------------------------------------
module dictzip_header_parser_tb;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we;
  logic [31:0]                 cfg_wdata;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [7:0]                  s_tdata;
  logic                        s_tlast;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [dzhp_pkg::TdataW-1:0] m_tdata;
  logic                        m_tlast;
  logic                        m_tuser;
  int                          fail_count;
  int                          pending;

  logic [7:0] file_q[$];
  int         burst_left;
  int         bytes_sent;
  longint     pend_end;

  dictzip_header_parser uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tlast (m_tlast),
    .m_axis_tuser (m_tuser)
  );

  dictzip_header_parser_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tlast_i   (s_tlast),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .m_tuser_i   (m_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // output stall pattern
  initial begin
    int mode;
    int cyc;
    mode     = 0;
    cyc      = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: m_tready = 1'b1;
        1: m_tready = 1'($urandom_range(0, 1));
        default: m_tready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic [31:0] crc_step(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = ~c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hedb8_8320) : (c >> 1);
    return ~c;
  endfunction

  task automatic add_byte(logic [7:0] b);
    file_q.insert(file_q.size(), b);
  endtask

  task automatic send_byte(logic [7:0] b, logic lst);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = lst;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;
    burst_left--;
    bytes_sent++;
  endtask

  // header into file_q; pend_end gets header length plus packed sizes
  task automatic make_header(logic [7:0] flg, int cnt, int xextra, logic crc_ok,
                             logic zero_len, logic big_sizes);
    int          xlen;
    int          n;
    int          hl;
    logic [15:0] v;
    logic [31:0] c;
    longint      total;
    file_q.delete();
    file_q = '{dzhp_pkg::Magic0, dzhp_pkg::Magic1, dzhp_pkg::MethodDf, flg};
    repeat (6) add_byte(8'($urandom_range(0, 255)));
    xlen = 10 + 2 * cnt + xextra;
    add_byte(xlen[7:0]);
    add_byte(xlen[15:8]);
    repeat (6) add_byte(8'($urandom_range(0, 255)));
    v = zero_len ? 16'd0 : 16'($urandom_range(1, 65535));
    add_byte(v[7:0]);
    add_byte(v[15:8]);
    v = 16'(cnt);
    add_byte(v[7:0]);
    add_byte(v[15:8]);
    total = 0;
    for (int i = 0; i < cnt; i++) begin
      v = big_sizes ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 60));
      add_byte(v[7:0]);
      add_byte(v[15:8]);
      total += v;
    end
    for (int i = 0; i < xextra; i++) add_byte(8'($urandom_range(0, 255)));
    hl = 12 + xlen;
    for (int k = 3; k <= 4; k++) begin
      if (flg[k]) begin
        n = $urandom_range(0, 4);
        repeat (n) add_byte(8'($urandom_range(1, 255)));
        add_byte(8'd0);
        hl += n + 1;
      end
    end
    if (flg[1]) begin
      c = '0;
      foreach (file_q[i]) c = crc_step(c, file_q[i]);
      if (!crc_ok) c[15:0] = c[15:0] ^ 16'($urandom_range(1, 65535));
      add_byte(c[7:0]);
      add_byte(c[15:8]);
      hl += 2;
    end
    pend_end = hl + total;
  endtask

  // cut < 0 sends the whole file plus a little payload
  task automatic send_file(int npay, int cut);
    int len;
    repeat (npay) add_byte(8'($urandom_range(0, 255)));
    len = (cut >= 0 && cut < file_q.size()) ? cut + 1 : file_q.size();
    for (int i = 0; i < len; i++) send_byte(file_q[i], i == len - 1);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_size(logic [31:0] v);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [7:0] rand_flags();
    return 8'($urandom_range(0, 255)) | 8'h04;
  endfunction

  initial begin
    int r;
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero file size gives a range error
    write_size(32'd0);
    make_header(8'h04, 2, 0, 1'b1, 1'b0, 1'b0);
    send_file(2, -1);
    // largest file size with name, comment, good header crc
    write_size(32'hffff_ffff);
    make_header(8'h1e, 3, 2, 1'b1, 1'b0, 1'b1);
    send_file(1, -1);
    make_header(8'h06, 1, 0, 1'b0, 1'b0, 1'b0);
    send_file(0, -1);
    // fixed header errors
    make_header(8'h04, 1, 0, 1'b1, 1'b0, 1'b0);
    file_q[0] = 8'h1e;
    file_q[2] = 8'd7;
    send_file(0, -1);
    make_header(8'h04, 1, 0, 1'b1, 1'b0, 1'b0);
    file_q[2] = 8'hff;
    send_file(0, -1);
    make_header(8'hfb, 1, 0, 1'b1, 1'b0, 1'b0);
    send_file(0, -1);
    // zero chunk length, zero chunk count
    make_header(8'h04, 1, 0, 1'b1, 1'b1, 1'b0);
    send_file(0, -1);
    make_header(8'h04, 0, 0, 1'b1, 1'b0, 1'b0);
    send_file(0, -1);
    // short extra field, then a long one
    make_header(8'h0c, 3, -5, 1'b1, 1'b0, 1'b0);
    send_file(0, -1);
    make_header(8'h04, 2, 7, 1'b1, 1'b0, 1'b0);
    send_file(0, -1);
    // truncated in the fixed header and inside the chunk table
    make_header(8'h04, 2, 0, 1'b1, 1'b0, 1'b0);
    send_file(0, 4);
    make_header(8'h04, 4, 0, 1'b1, 1'b0, 1'b0);
    send_file(0, 25);
    // trailer room of exactly eight and of seven bytes
    make_header(8'h04, 2, 0, 1'b1, 1'b0, 1'b0);
    write_size(32'(pend_end + 8));
    send_file(0, -1);
    make_header(8'h04, 2, 0, 1'b1, 1'b0, 1'b0);
    write_size(32'(pend_end + 7));
    send_file(0, -1);
    // a single byte file
    send_byte(8'h1f, 1'b1);

    while (bytes_sent < 700) begin
      r = $urandom_range(0, 9);
      if (r <= 6) begin
        make_header(rand_flags(), $urandom_range(1, 6), $urandom_range(0, 3),
                    $urandom_range(0, 5) != 0, $urandom_range(0, 15) == 0,
                    $urandom_range(0, 5) == 0);
        if ($urandom_range(0, 3) != 0)
          write_size(32'(pend_end + $urandom_range(6, 12)));
        else if ($urandom_range(0, 3) == 0)
          write_size($urandom_range(0, 1) ? 32'hffff_ffff : 32'($urandom()));
        send_file($urandom_range(0, 4), -1);
      end else if (r == 7) begin
        make_header(8'($urandom_range(0, 255)), $urandom_range(0, 4),
                    $urandom_range(0, 2), 1'b1, 1'b0, 1'b0);
        file_q[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
        send_file($urandom_range(0, 3), -1);
      end else if (r == 8) begin
        file_q.delete();
        repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) file_q[0] = dzhp_pkg::Magic0;
        send_file(0, -1);
      end else begin
        make_header(rand_flags(), $urandom_range(1, 5), $urandom_range(0, 3),
                    1'b1, 1'b0, 1'b0);
        send_file(0, $urandom_range(0, file_q.size() - 1));
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dzhp_pkg.sv
rtl/dzhp_front.sv
rtl/dzhp_fifo.sv
rtl/dzhp_back.sv
rtl/dictzip_header_parser.sv
dv/dictzip_header_parser_checker.sv
dv/dictzip_header_parser_tb.sv
